/* rtl/vertex_transform_project_macros.svh */
// ----------------------------------------------------------------------------
// vertex transform assertion macros
// concurrent check wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef VERTEX_TRANSFORM_PROJECT_MACROS_SVH
`define VERTEX_TRANSFORM_PROJECT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VTP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtp check failed");
// next-cycle implication
`define VTP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtp check failed");
`else
`define VTP_ASSERT_IMP(label, ante, cons)
`define VTP_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/vtp_pkg.sv */
// ----------------------------------------------------------------------------
// vtp_pkg
// shared types and constants of the vertex transform block
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

  // number formats
  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int PROD_W    = 2 * DW;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_W     = DW + FRAC_BITS;

  // register file
  localparam int NREGS     = 8;
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 3;
  localparam int ADDR_W    = REG_IDX_W + 3;

  // pipeline shape
  localparam int XF_STAGES = 3;
  localparam int NST       = XF_STAGES + 1 + NUM_W + 1;

  localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam logic [REG_W-1:0] ONE_HI = ONE_LO << DW;

  // identity matrix held by the register file after reset
  localparam logic [NREGS-1:0][REG_W-1:0] MAT_RESET = {
    ONE_HI, REG_W'(0), ONE_LO, REG_W'(0), REG_W'(0), ONE_HI, REG_W'(0), ONE_LO
  };

  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(1) << (FRAC_BITS - 1);

  localparam logic [NUM_W-1:0] NEG_LIM = NUM_W'(1) << (DW - 1);
  localparam logic [NUM_W-1:0] POS_LIM = NEG_LIM - NUM_W'(1);

  localparam logic [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic                 mode;
    logic signed [DW-1:0] in_x;
    logic signed [DW-1:0] in_y;
    logic signed [DW-1:0] in_z;
    logic signed [DW-1:0] in_w;
  } vtp_in_t;

  typedef struct packed {
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic signed [DW-1:0] out_z;
    logic signed [DW-1:0] out_w;
    logic                 w_was_zero;
    logic                 saturated;
  } vtp_out_t;

  // transform result handed to the divider
  typedef struct packed {
    logic               mode;
    logic               clip;
    logic [3:0][DW-1:0] res;
  } vtp_xf_t;

  // state carried along the divider chain
  typedef struct packed {
    logic                  project;
    logic                  wzero;
    logic                  clip;
    logic [3:0][DW-1:0]    res;
    logic [2:0]            neg;
    logic [DW-1:0]         den;
    logic [2:0][DW-1:0]    rem;
    logic [2:0][NUM_W-1:0] num;
  } vtp_div_t;

endpackage

`default_nettype wire

/* rtl/vtp_xform.sv */
// ----------------------------------------------------------------------------
// vtp_xform
// matrix times vertex: products, pair sums, round and saturate
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_xform import vtp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [XF_STAGES-1:0]        rdy,
  input  logic                        in_vld,
  input  vtp_in_t                     in_item,
  input  logic [NREGS-1:0][REG_W-1:0] mat,
  output logic [XF_STAGES-1:0]        vld,
  output vtp_xf_t                     res
);

  logic signed [DW-1:0]    vec  [4];
  logic signed [DW-1:0]    cf   [4][4];
  logic signed [PROD_W-1:0] prod [4][4];
  logic signed [SUM_W-1:0] psum [4][2];
  logic signed [SUM_W-1:0] tot  [4];
  logic signed [SUM_W-1:0] rnd  [4];
  logic [DW-1:0]           val  [4];
  logic [3:0]              clip;
  logic                    mode1;
  logic                    mode2;

  // operand selection
  always_comb begin
    vec[0] = in_item.in_x;
    vec[1] = in_item.in_y;
    vec[2] = in_item.in_z;
    vec[3] = in_item.in_w;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        cf[r][c] = mat[2*r + c/2][(c%2)*DW +: DW];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_vld;
      if (rdy[1]) vld[1] <= vld[0];
      if (rdy[2]) vld[2] <= vld[1];
    end
  end

  // stage 1: sixteen products
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      mode1 <= in_item.mode;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          prod[r][c] <= cf[r][c] * vec[c];
        end
      end
    end
  end

  // stage 2: pair sums
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      mode2 <= mode1;
      for (int r = 0; r < 4; r++) begin
        psum[r][0] <= SUM_W'(prod[r][0]) + SUM_W'(prod[r][1]);
        psum[r][1] <= SUM_W'(prod[r][2]) + SUM_W'(prod[r][3]);
      end
    end
  end

  // stage 3: round half up and saturate
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      tot[r] = psum[r][0] + psum[r][1] + ROUND;
      rnd[r] = tot[r] >>> FRAC_BITS;
      clip[r] = !((&rnd[r][SUM_W-1:DW-1]) || !(|rnd[r][SUM_W-1:DW-1]));
      if (clip[r]) begin
        val[r] = rnd[r][SUM_W-1] ? SAT_MIN : SAT_MAX;
      end else begin
        val[r] = rnd[r][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      res.mode <= mode2;
      res.clip <= |clip;
      for (int r = 0; r < 4; r++) begin
        res.res[r] <= val[r];
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/vtp_div_cell.sv */
// ----------------------------------------------------------------------------
// vtp_div_cell
// one restoring divide step for x, y and z, one quotient bit per cell
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_div_cell import vtp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  logic     in_vld,
  input  vtp_div_t in_dat,
  output logic     out_vld,
  output vtp_div_t out_dat
);

  logic [DW:0]   trial [3];
  logic [DW:0]   diff  [3];
  logic [2:0]    ge;
  vtp_div_t      nxt;

  // shift in the next numerator bit, subtract where it fits
  always_comb begin
    nxt = in_dat;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {in_dat.rem[l], in_dat.num[l][NUM_W-1]};
      diff[l]  = trial[l] - {1'b0, in_dat.den};
      ge[l]    = trial[l] >= {1'b0, in_dat.den};
      nxt.rem[l] = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
      nxt.num[l] = {in_dat.num[l][NUM_W-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (load) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_dat <= nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/vertex_transform_project.sv */
// ----------------------------------------------------------------------------
// vertex_transform_project
// 4x4 matrix times homogeneous vertex with optional perspective divide
// ----------------------------------------------------------------------------
// Input channel in_valid/in_data/in_stall carries one vertex and a mode bit
// per transaction; output channel out_valid/out_data/out_stall carries one
// result per vertex, in order. The matrix sits in eight 64-bit registers on
// the APB port at byte address 8*i, identity after reset.
// There are 53 register stages: three transform stages (products, pair sums,
// round and saturate), one divider set-up stage, a row of 48 divider cells,
// one per quotient bit, and the output register.
// Throughput is one vertex per clock while out_stall is low; every stage
// holds one transaction.
// When out_stall is high the output holds and stages behind it fill up one
// by one; in_stall rises only once the first stage is occupied and blocked.
// Reset clears all valid bits and reloads the identity matrix.
// Write the matrix only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_transform_project_macros.svh"

module vertex_transform_project import vtp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  vtp_in_t           in_data,
  output logic              in_stall,
  output logic              out_valid,
  output vtp_out_t          out_data,
  input  logic              out_stall,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready
);

  logic [NREGS-1:0][REG_W-1:0] mat;
  logic [REG_IDX_W-1:0]        reg_idx;
  logic [NST:0]                rdy;
  logic [NST-1:0]              vld_all;
  logic [XF_STAGES-1:0]        xf_vld;
  vtp_xf_t                     xf_res;
  logic                        p_vld;
  vtp_div_t                    p_dat;
  vtp_div_t                    p_next;
  logic                        cv [NUM_W+1];
  vtp_div_t                    cd [NUM_W+1];
  vtp_out_t                    out_next;
  logic [NUM_W-1:0]            q     [3];
  logic [NUM_W-1:0]            q_neg [3];
  logic [2:0]                  dclip;
  logic [DW-1:0]               dval  [3];

  // register file
  assign reg_idx = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign pready  = 1'b1;
  assign prdata  = mat[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      mat[reg_idx] <= pwdata;
    end
  end

  // flow control: a stage loads when empty or when its successor moves
  always_comb begin
    vld_all[XF_STAGES-1:0] = xf_vld;
    vld_all[XF_STAGES]     = p_vld;
    for (int k = 0; k < NUM_W; k++) begin
      vld_all[XF_STAGES+1+k] = cv[k+1];
    end
    vld_all[NST-1] = out_valid;
    rdy[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_all[k] || rdy[k+1];
    end
  end

  assign in_stall = !rdy[0];

  // transform
  vtp_xform u_xform (
    .clk     (clk),
    .rst     (rst),
    .rdy     (rdy[XF_STAGES-1:0]),
    .in_vld  (in_valid),
    .in_item (in_data),
    .mat     (mat),
    .vld     (xf_vld),
    .res     (xf_res)
  );

  // divider set-up: magnitudes and signs
  always_comb begin
    p_next.res     = xf_res.res;
    p_next.clip    = xf_res.clip;
    p_next.wzero   = xf_res.mode && (xf_res.res[3] == '0);
    p_next.project = xf_res.mode && (xf_res.res[3] != '0);
    p_next.den     = xf_res.res[3][DW-1] ? (~xf_res.res[3] + DW'(1)) : xf_res.res[3];
    for (int l = 0; l < 3; l++) begin
      p_next.neg[l] = xf_res.res[l][DW-1] ^ xf_res.res[3][DW-1];
      p_next.rem[l] = '0;
      p_next.num[l] = {(xf_res.res[l][DW-1] ? (~xf_res.res[l] + DW'(1)) : xf_res.res[l]),
                       FRAC_BITS'(0)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (rdy[XF_STAGES]) begin
      p_vld <= xf_vld[XF_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[XF_STAGES]) begin
      p_dat <= p_next;
    end
  end

  assign cv[0] = p_vld;
  assign cd[0] = p_dat;

  // divider chain
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    vtp_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (rdy[XF_STAGES+1+k]),
      .in_vld  (cv[k]),
      .in_dat  (cd[k]),
      .out_vld (cv[k+1]),
      .out_dat (cd[k+1])
    );
  end

  // sign, saturation and output select
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      q[l]     = cd[NUM_W].num[l];
      q_neg[l] = ~q[l] + NUM_W'(1);
      if (cd[NUM_W].neg[l]) begin
        dclip[l] = q[l] > NEG_LIM;
        dval[l]  = dclip[l] ? SAT_MIN : q_neg[l][DW-1:0];
      end else begin
        dclip[l] = q[l] > POS_LIM;
        dval[l]  = dclip[l] ? SAT_MAX : q[l][DW-1:0];
      end
    end
    out_next.out_w      = cd[NUM_W].res[3];
    out_next.w_was_zero = cd[NUM_W].wzero;
    if (cd[NUM_W].project) begin
      out_next.out_x     = dval[0];
      out_next.out_y     = dval[1];
      out_next.out_z     = dval[2];
      out_next.saturated = cd[NUM_W].clip || (|dclip);
    end else begin
      out_next.out_x     = cd[NUM_W].res[0];
      out_next.out_y     = cd[NUM_W].res[1];
      out_next.out_z     = cd[NUM_W].res[2];
      out_next.saturated = cd[NUM_W].clip;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy[NST-1]) begin
      out_valid <= cv[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      out_data <= out_next;
    end
  end

  // checks
  `VTP_ASSERT_IMP(a_wzero_w, out_valid && out_data.w_was_zero, out_data.out_w == '0)
  `VTP_ASSERT_NXT(a_head_hold, vld_all[0] && !rdy[1], vld_all[0])

endmodule

`default_nettype wire

/* dv/vertex_transform_project_check.sv */
// ----------------------------------------------------------------------------
// vertex_transform_project_check
// watches both channels and the register port, predicts each output vertex
// and compares it field by field with what the block delivers
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_project_check import vtp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire vtp_in_t           in_data,
  input  wire logic              in_stall,
  input  wire logic              out_valid,
  input  wire vtp_out_t          out_data,
  input  wire logic              out_stall,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  input  wire logic              pready,
  output int                     pending,
  output int                     failures
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [REG_W-1:0] matrix [NREGS];
  vtp_out_t         expected_q [$];

  // signed coefficient (r,c) of the shadow matrix
  function automatic int coef(int r, int c);
    logic [REG_W-1:0] word;
    word = matrix[r * 2 + c / 2];
    return (c % 2) ? int'(word[63:32]) : int'(word[31:0]);
  endfunction

  function automatic longint clip32(longint v, inout logic clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // matrix product, round half up, saturate, then optional divide
  function automatic vtp_out_t transform_vertex(vtp_in_t v);
    int                       vec [4];
    longint                   res [4];
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  rounded;
    longint                   num;
    logic                     clipped;
    vtp_out_t                 o;
    vec[0] = v.in_x;
    vec[1] = v.in_y;
    vec[2] = v.in_z;
    vec[3] = v.in_w;
    clipped = 1'b0;
    for (int r = 0; r < 4; r++) begin
      acc = '0;
      for (int c = 0; c < 4; c++)
        acc += SUM_W'(longint'(coef(r, c)) * longint'(vec[c]));
      rounded = (acc + (SUM_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      res[r] = clip32(longint'(rounded), clipped);
    end
    o.w_was_zero = 1'b0;
    if (v.mode) begin
      if (res[3] == 0) begin
        o.w_was_zero = 1'b1;
      end else begin
        for (int i = 0; i < 3; i++) begin
          num = res[i] * (64'sd1 <<< FRAC_BITS);
          res[i] = clip32(num / res[3], clipped);
        end
      end
    end
    o.out_x = res[0][31:0];
    o.out_y = res[1][31:0];
    o.out_z = res[2][31:0];
    o.out_w = res[3][31:0];
    o.saturated = clipped;
    return o;
  endfunction

  task automatic report_mismatch(string what, vtp_out_t exp_v, vtp_out_t act_v);
    failures++;
    if (failures <= 10) begin
      $display("%0t mismatch %s: expected x=%h y=%h z=%h w=%h wz=%b sat=%b",
               $realtime, what, exp_v.out_x, exp_v.out_y, exp_v.out_z, exp_v.out_w,
               exp_v.w_was_zero, exp_v.saturated);
      $display("%0t mismatch %s: got      x=%h y=%h z=%h w=%h wz=%b sat=%b",
               $realtime, what, act_v.out_x, act_v.out_y, act_v.out_z, act_v.out_w,
               act_v.w_was_zero, act_v.saturated);
    end
  endtask

  initial failures = 0;
  assign pending = expected_q.size();

  // shadow registers follow every write transaction
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++)
        matrix[i] <= MAT_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      matrix[paddr >> 3] <= pwdata;
    end
  end

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    vtp_out_t exp_v;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_q.push_back(transform_vertex(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", '0, out_data);
        end else begin
          exp_v = expected_q.pop_front();
          if (exp_v.out_x !== out_data.out_x || exp_v.out_y !== out_data.out_y ||
              exp_v.out_z !== out_data.out_z || exp_v.out_w !== out_data.out_w ||
              exp_v.w_was_zero !== out_data.w_was_zero ||
              exp_v.saturated !== out_data.saturated)
            report_mismatch("result", exp_v, out_data);
        end
      end
    end
  end

endmodule

`default_nettype wire

/* dv/vertex_transform_project_test.sv */
// ----------------------------------------------------------------------------
// vertex_transform_project_test
// drives vertices through several matrix settings with bursty input and
// random output stall; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_transform_project_test import vtp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  vtp_in_t           in_data = '0;
  logic              in_stall;
  logic              out_valid;
  vtp_out_t          out_data;
  logic              out_stall = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [REG_W-1:0]  pwdata = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;
  int                pending;
  int                failures;
  int                burst_left = 0;
  int                stall_style = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_transform_project DUT (
    .clk, .rst, .in_valid, .in_data, .in_stall, .out_valid, .out_data, .out_stall,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  vertex_transform_project_check checker_i (
    .clk, .rst, .in_valid, .in_data, .in_stall, .out_valid, .out_data, .out_stall,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .failures
  );

  // receiver stall, pattern style changes now and then
  always @(negedge clk) begin
    if ($urandom_range(0, 150) == 0)
      stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // one register write transaction
  task automatic write_reg(int idx, logic [REG_W-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = ADDR_W'(idx * 8);
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // drain the pipeline before touching the matrix
  task automatic wait_drained();
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0)
      @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // one input transaction, called at a falling edge, returns at a falling edge
  task automatic send_vertex(vtp_in_t v);
    logic taken;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 6) : 0) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid = 1'b1;
    in_data = v;
    // acceptance is judged at the rising edge
    do begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end while (!taken);
    if (burst_left == 0)
      in_valid = 1'b0;
  endtask

  function automatic logic [31:0] rand_coord(int shape);
    case (shape)
      0: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
      1: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
      2: return $urandom;
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic vtp_in_t rand_vertex();
    vtp_in_t v;
    int      shape;
    shape = $urandom_range(0, 9) < 6 ? $urandom_range(0, 1) : $urandom_range(2, 3);
    v.mode = 1'($urandom_range(0, 1));
    v.in_x = rand_coord(shape);
    v.in_y = rand_coord(shape);
    v.in_z = rand_coord(shape);
    case ($urandom_range(0, 7))
      0: v.in_w = 32'h0;
      1: v.in_w = 32'h10000;
      default: v.in_w = rand_coord(shape);
    endcase
    return v;
  endfunction

  // full matrix of one flavour: 0 random small, 1 random full, 2 max, 3 min, 4 zero
  task automatic load_matrix(int flavour);
    logic [31:0] c [2];
    for (int i = 0; i < NREGS; i++) begin
      for (int h = 0; h < 2; h++)
        case (flavour)
          0: c[h] = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
          1: c[h] = $urandom;
          2: c[h] = 32'h7fffffff;
          3: c[h] = 32'h80000000;
          default: c[h] = 32'h0;
        endcase
      write_reg(i, {c[1], c[0]});
    end
  endtask

  initial begin
    #5ms;
    $display("vertex_transform_project_test NOT OK");
    $finish;
  end

  initial begin
    vtp_in_t directed [$];
    int      flavours [8] = '{0, 1, 2, 3, 4, 0, 1, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed vertices under the reset identity matrix
    directed.push_back('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0});
    directed.push_back('{1'b1, 32'h0, 32'h0, 32'h0, 32'h0});
    directed.push_back('{1'b0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
    directed.push_back('{1'b1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
    directed.push_back('{1'b1, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffff0000});
    directed.push_back('{1'b1, 32'h7fffffff, 32'h80000000, 32'h10000, 32'h1});
    directed.push_back('{1'b1, 32'h30000, 32'hfffd0000, 32'h8000, 32'h20000});
    directed.push_back('{1'b1, 32'h10000, 32'h20000, 32'h30000, 32'h0});
    directed.push_back('{1'b0, 32'h10000, 32'h20000, 32'h30000, 32'h0});
    directed.push_back('{1'b1, 32'h1, 32'hffffffff, 32'h3, 32'h3});
    directed.push_back('{1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
    directed.push_back('{1'b0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
    directed.push_back('{1'b1, 32'h55555555, 32'haaaaaaaa, 32'h12345678, 32'hfffe0000});
    foreach (directed[i])
      send_vertex(directed[i]);
    repeat (60) send_vertex(rand_vertex());

    // random vertices under a sequence of matrices
    foreach (flavours[f]) begin
      wait_drained();
      load_matrix(flavours[f]);
      // rounding corner: a quarter coefficient meets inputs of 2 and -2
      if (f == 0) begin
        write_reg(0, {32'h0, 32'h4000});
        send_vertex('{1'b0, 32'h2, 32'h0, 32'h0, 32'h10000});
        send_vertex('{1'b0, 32'hfffffffe, 32'h0, 32'h0, 32'h10000});
      end
      repeat (170) send_vertex(rand_vertex());
    end

    // back to identity for a last stretch
    wait_drained();
    write_reg(0, ONE_LO);
    write_reg(1, '0);
    write_reg(2, ONE_HI);
    write_reg(3, '0);
    write_reg(4, '0);
    write_reg(5, ONE_LO);
    write_reg(6, '0);
    write_reg(7, ONE_HI);
    repeat (30) send_vertex(rand_vertex());

    in_valid = 1'b0;
    wait_drained();
    if (failures == 0)
      $display("vertex_transform_project_test OK");
    else
      $display("vertex_transform_project_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
